### src/csl_pkg.sv
// shared types and constants for the cursor sequence list
// no dependencies; used by csl_seq and cursor_sequence_list
package csl_pkg;

    // default capacity of the list
    localparam int CAP_DEF = 32;

    // fixed field widths
    localparam int VAL_W     = 64;
    localparam int KIND_W    = 3;
    localparam int CNT_OUT_W = 6;

    // command codes
    typedef enum logic [KIND_W-1:0] {
        KIND_START   = 3'd0,
        KIND_ADVANCE = 3'd1,
        KIND_INSERT  = 3'd2,
        KIND_ATTACH  = 3'd3,
        KIND_REMOVE  = 3'd4
    } t_kind;

    // status from the sequencer to the top level
    typedef struct packed {
        logic busy;
        logic strobe;
        logic has_cur;
        logic err;
    } t_csl_status;

endpackage

### src/csl_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module csl_ram #(
    parameter int W = 64,
    parameter int D = 32,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/csl_seq.sv
// command sequencer: decodes a command, updates count and cursor, and
// moves entries one at a time through the ram, a read then a write each; uses csl_pkg
module csl_seq #(
    parameter int CAP = csl_pkg::CAP_DEF,
    parameter int IW = (CAP > 1) ? $clog2(CAP) : 1,
    parameter int CW = $clog2(CAP + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [csl_pkg::KIND_W-1:0] i_kind,
    input  logic [csl_pkg::VAL_W-1:0]  i_value,
    output csl_pkg::t_csl_status      o_stat,
    output logic [CW-1:0]             o_count,
    output logic                      o_we,
    output logic [IW-1:0]             o_waddr,
    output logic [csl_pkg::VAL_W-1:0]  o_wdata,
    output logic [IW-1:0]             o_raddr,
    input  logic [csl_pkg::VAL_W-1:0]  i_rdata
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SRD  = 6'b000010,
        S_SWR  = 6'b000100,
        S_PUT  = 6'b001000,
        S_CRD  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [IW-1:0]            r_cursor, n_cursor;
    logic                     r_valid, n_valid;
    logic                     r_err, n_err;
    logic                     r_open, n_open;
    logic [IW-1:0]            r_idx, n_idx;
    logic [IW-1:0]            r_pos, n_pos;
    logic [IW-1:0]            r_lim, n_lim;
    logic [csl_pkg::VAL_W-1:0] r_val, n_val;

    logic          w_accept;
    logic          w_full;
    logic [IW-1:0] w_idx_dn;
    logic [IW-1:0] w_idx_up;
    logic [IW-1:0] w_cur_inc;
    logic [CW-1:0] w_cur_ext;

    assign w_accept  = i_start && (r_state == S_IDLE);
    assign w_full    = (r_count >= CW'(CAP));
    assign w_idx_dn  = r_idx - IW'(1);
    assign w_idx_up  = r_idx + IW'(1);
    assign w_cur_inc = r_cursor + IW'(1);
    assign w_cur_ext = CW'(r_cursor);

    // next state and datapath control
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_valid  = r_valid;
        n_err    = r_err;
        n_open   = r_open;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_lim    = r_lim;
        n_val    = r_val;
        o_we     = 1'b0;
        o_waddr  = r_idx;
        o_wdata  = i_rdata;
        o_raddr  = r_cursor;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_err   = 1'b0;
                    n_val   = i_value;
                    n_state = S_CRD;
                    unique case (csl_pkg::t_kind'(i_kind))
                        csl_pkg::KIND_START: begin
                            n_cursor = '0;
                            n_valid  = (r_count != '0);
                        end
                        csl_pkg::KIND_ADVANCE: begin
                            if (!r_valid) begin
                                n_err = 1'b1;
                            end else if (w_cur_ext + CW'(1) >= r_count) begin
                                n_valid = 1'b0;
                            end else begin
                                n_cursor = w_cur_inc;
                            end
                        end
                        csl_pkg::KIND_INSERT, csl_pkg::KIND_ATTACH: begin
                            if (w_full) begin
                                n_err = 1'b1;
                            end else begin
                                // position of the new word
                                if (csl_pkg::t_kind'(i_kind) == csl_pkg::KIND_INSERT) begin
                                    n_pos = r_valid ? r_cursor : '0;
                                end else begin
                                    n_pos = r_valid ? w_cur_inc : IW'(r_count);
                                end
                                n_cursor = n_pos;
                                n_valid  = 1'b1;
                                n_count  = r_count + CW'(1);
                                n_open   = 1'b1;
                                n_idx    = IW'(r_count);
                                n_state  = (r_count > CW'(n_pos)) ? S_SRD : S_PUT;
                            end
                        end
                        csl_pkg::KIND_REMOVE: begin
                            if (!r_valid) begin
                                n_err = 1'b1;
                            end else begin
                                n_count = r_count - CW'(1);
                                n_valid = (w_cur_ext < n_count);
                                n_open  = 1'b0;
                                n_idx   = r_cursor;
                                n_lim   = IW'(n_count);
                                if (w_cur_ext < n_count) begin
                                    n_state = S_SRD;
                                end
                            end
                        end
                        default: begin
                            n_err = 1'b1;
                        end
                    endcase
                end
            end
            S_SRD: begin
                // fetch the entry that moves into r_idx
                o_raddr = r_open ? w_idx_dn : w_idx_up;
                n_state = S_SWR;
            end
            S_SWR: begin
                // store the moved entry
                o_we    = 1'b1;
                o_waddr = r_idx;
                o_wdata = i_rdata;
                if (r_open) begin
                    n_idx   = w_idx_dn;
                    n_state = (w_idx_dn > r_pos) ? S_SRD : S_PUT;
                end else begin
                    n_idx   = w_idx_up;
                    n_state = (w_idx_up < r_lim) ? S_SRD : S_CRD;
                end
            end
            S_PUT: begin
                // place the new word in the gap
                o_we    = 1'b1;
                o_waddr = r_pos;
                o_wdata = r_val;
                n_state = S_CRD;
            end
            S_CRD: begin
                o_raddr = r_cursor;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_valid  <= 1'b0;
            r_err    <= 1'b0;
            r_open   <= 1'b0;
            r_idx    <= '0;
            r_pos    <= '0;
            r_lim    <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_valid  <= n_valid;
            r_err    <= n_err;
            r_open   <= n_open;
            r_idx    <= n_idx;
            r_pos    <= n_pos;
            r_lim    <= n_lim;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_stat.busy    = (r_state != S_IDLE);
    assign o_stat.strobe  = (r_state == S_OUT);
    assign o_stat.has_cur = r_valid;
    assign o_stat.err     = r_err;
    assign o_count        = r_count;

endmodule

### src/cursor_sequence_list.sv
// cursor sequence list top level: entry ram, command sequencer, result ports
// start/advance and refused commands pass through S_CRD to the strobe in S_OUT
// insert/attach: S_SRD, S_SWR per entry, S_PUT, S_CRD, S_OUT; remove: no S_PUT
// busy stays high through the strobe cycle; a new transfer can be taken in the cycle after it
// synchronous active-low reset empties the list; entry ram is not cleared
// the receiver cannot stall: each result is on the ports for one cycle
module cursor_sequence_list #(
    parameter int CAP = csl_pkg::CAP_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [csl_pkg::KIND_W-1:0]     i_kind,
    input  logic [csl_pkg::VAL_W-1:0]      i_value,
    output logic                           o_valid,
    output logic [csl_pkg::CNT_OUT_W-1:0]  o_count,
    output logic                           o_has_current,
    output logic [csl_pkg::VAL_W-1:0]      o_current_value,
    output logic                           o_error
);

    localparam int IW = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CW = $clog2(CAP + 1);
    localparam int XW = (CW > csl_pkg::CNT_OUT_W) ? CW : csl_pkg::CNT_OUT_W;

    csl_pkg::t_csl_status       w_stat;
    logic [CW-1:0]              w_count;
    logic [XW-1:0]              w_count_ext;
    logic                       w_we;
    logic [IW-1:0]              w_waddr;
    logic [csl_pkg::VAL_W-1:0]  w_wdata;
    logic [IW-1:0]              w_raddr;
    logic [csl_pkg::VAL_W-1:0]  w_rdata;

    // sequencer
    csl_seq #(
        .CAP (CAP),
        .IW  (IW),
        .CW  (CW)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_value (i_value),
        .o_stat  (w_stat),
        .o_count (w_count),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata),
        .o_raddr (w_raddr),
        .i_rdata (w_rdata)
    );

    // entry storage
    csl_ram #(
        .W  (csl_pkg::VAL_W),
        .D  (CAP),
        .AW (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // result formatting, count carries its low bits
    assign w_count_ext     = XW'(w_count);
    assign busy            = w_stat.busy;
    assign o_valid         = w_stat.strobe;
    assign o_count         = w_count_ext[csl_pkg::CNT_OUT_W-1:0];
    assign o_has_current   = w_stat.has_cur;
    assign o_current_value = w_stat.has_cur ? w_rdata : '0;
    assign o_error         = w_stat.err;

endmodule
